/* rtl/htc_pkg.sv */
// ----------------------------------------------------------------------------
// htc_pkg: shared constants and types of the humidity/temperature converter
// Field widths, fixed-point coefficients, register indexes and the records
// that travel between the pipeline modules.
// ----------------------------------------------------------------------------
package htc_pkg;

	// Fractional bits of the humidity accumulator and coefficients
	localparam int FRAC_BITS = 24;

	// Field widths
	localparam int RT_W   = 14;
	localparam int RH_W   = 12;
	localparam int TEMP_W = 15;
	localparam int HUM_W  = 14;
	localparam int THR_W  = 15;
	localparam int TOFF_W = 14;
	localparam int HOFF_W = 11;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_ALARM_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_OFF  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_OFF   = 2'd2;

	localparam int RST_ALARM_THR = 3000;
	localparam int RST_TEMP_OFF  = -4000;
	localparam int RST_HUM_OFF   = -400;

	// Coefficients, rounded to nearest from the exact values (in hundredths)
	localparam longint unsigned K2  = ((64'd405 << FRAC_BITS) + 64'd50) / 64'd100;
	localparam longint unsigned K3  = ((64'd28 << FRAC_BITS) + 64'd50000) / 64'd100000;
	localparam longint unsigned KT1 = ((64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
	localparam longint unsigned KT2 = ((64'd1 << FRAC_BITS) + 64'd6250) / 64'd12500;

	localparam longint unsigned RH_MAX = (64'd1 << RH_W) - 64'd1;

	localparam int K2_W  = $clog2(K2 + 64'd1);
	localparam int K3_W  = $clog2(K3 + 64'd1);
	localparam int KTS_W = $clog2(KT1 + KT2 * RH_MAX + 64'd1);

	// Intermediate widths
	localparam int TC_W    = RT_W + 2;               // raw + offset, signed
	localparam int TCM_W   = TC_W + 1;               // temperature minus base
	localparam int RH2_W   = 2 * RH_W;
	localparam int K2RH_W  = K2_W + RH_W;
	localparam int K3RH2_W = K3_W + RH2_W;
	localparam int TPROD_W = TCM_W + KTS_W + 1;
	localparam int ACC_W   = FRAC_BITS + 18;
	localparam int HQ_W    = ACC_W - FRAC_BITS;

	// Compensation base (25.00 degrees) and output limits
	localparam int T_BASE   = 2500;
	localparam int TEMP_MAX = (1 << (TEMP_W - 1)) - 1;
	localparam int TEMP_MIN = -(1 << (TEMP_W - 1));
	localparam int HUM_MIN  = 10;
	localparam int HUM_MAX  = 10000;

	typedef struct packed {
		logic signed [THR_W-1:0]  alarm_threshold;
		logic signed [TOFF_W-1:0] temp_offset;
		logic signed [HOFF_W-1:0] humidity_offset;
	} htc_cfg_t;

	// Products handed from the multiplier stages to the summing stages
	typedef struct packed {
		logic signed [TEMP_W-1:0]  temperature;
		logic                      alarm;
		logic [K2RH_W-1:0]         k2rh;
		logic [K3RH2_W-1:0]        k3rh2;
		logic signed [TPROD_W-1:0] tprod;
	} htc_prod_t;

endpackage

/* rtl/htc_if.sv */
// ----------------------------------------------------------------------------
// htc_if: channel interfaces of the humidity/temperature converter
// Sample input, result output and register write channels, each with
// valid/ready handshake and a source and a sink modport.
// ----------------------------------------------------------------------------
interface htc_in_if;
	import htc_pkg::*;

	logic            valid;
	logic            ready;
	logic [RT_W-1:0] raw_temperature;
	logic [RH_W-1:0] raw_humidity;

	modport source (output valid, output raw_temperature, output raw_humidity, input ready);
	modport sink   (input valid, input raw_temperature, input raw_humidity, output ready);
endinterface

interface htc_out_if;
	import htc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temperature_centi;
	logic [HUM_W-1:0]         humidity_centi;
	logic                     alarm;

	modport source (output valid, output temperature_centi, output humidity_centi,
		output alarm, input ready);
	modport sink   (input valid, input temperature_centi, input humidity_centi,
		input alarm, output ready);
endinterface

interface htc_cfg_if;
	import htc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/humidity_temperature_compensation_unit.sv */
// ----------------------------------------------------------------------------
// humidity_temperature_compensation_unit: sensor reading converter
// Converts a raw temperature/humidity pair into hundredths of a degree and
// compensated, clamped hundredths of %RH, with a temperature alarm bit.
//
//   channel  role    handshake     payload
//   sample   sink    valid/ready   raw_temperature, raw_humidity
//   result   source  valid/ready   temperature_centi, humidity_centi, alarm
//   cfg      sink    valid/ready   index, data (ready always high)
//
// One transaction enters per cycle unless the pipe is stalled full; each
// sample passes two multiplier stages, two adder stages, output register.
// Reset clears the stage valid bits and loads the register reset values.
// A stalled result holds every stage that is full; empty stages keep
// filling, so sample.ready drops only when the whole pipe is full.
// ----------------------------------------------------------------------------
module humidity_temperature_compensation_unit (
	input  logic      clk,
	input  logic      arst_n,
	htc_in_if.sink    sample,
	htc_out_if.source result,
	htc_cfg_if.sink   cfg
);
	import htc_pkg::*;

	htc_cfg_t  regs;
	htc_prod_t prod;
	logic      prod_valid;
	logic      prod_ready;

	// Register file
	htc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Multiplier stages
	htc_mult u_mult (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.cfg        (regs),
		.prod_valid (prod_valid),
		.prod_ready (prod_ready),
		.prod       (prod)
	);

	// Summing stages and output register
	htc_sum u_sum (
		.clk        (clk),
		.arst_n     (arst_n),
		.prod_valid (prod_valid),
		.prod_ready (prod_ready),
		.prod       (prod),
		.cfg        (regs),
		.result     (result)
	);

endmodule

/* rtl/htc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// htc_cfg_regs: configuration register file
// Holds alarm threshold, temperature offset and humidity offset; a write to
// an index beyond the list is dropped.
// ----------------------------------------------------------------------------
module htc_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	htc_cfg_if.sink          cfg,
	output htc_pkg::htc_cfg_t regs
);
	import htc_pkg::*;

	htc_cfg_t regs_q;

	// Always take a write transaction
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Update the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.alarm_threshold <= THR_W'(RST_ALARM_THR);
			regs_q.temp_offset     <= TOFF_W'(RST_TEMP_OFF);
			regs_q.humidity_offset <= HOFF_W'(RST_HUM_OFF);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ALARM_THR: regs_q.alarm_threshold <= cfg.data[THR_W-1:0];
				REG_TEMP_OFF:  regs_q.temp_offset     <= cfg.data[TOFF_W-1:0];
				REG_HUM_OFF:   regs_q.humidity_offset <= cfg.data[HOFF_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* rtl/htc_mult.sv */
// ----------------------------------------------------------------------------
// htc_mult: multiplier stages s1 and s2
// s1 forms the offset temperature, rh squared, K2*rh and the compensation
// slope; s2 forms K3*rh^2, the temperature compensation product, the
// saturated temperature and the alarm bit.
// ----------------------------------------------------------------------------
module htc_mult (
	input  logic              clk,
	input  logic              arst_n,
	htc_in_if.sink            sample,
	input  htc_pkg::htc_cfg_t cfg,
	output logic              prod_valid,
	input  logic              prod_ready,
	output htc_pkg::htc_prod_t prod
);
	import htc_pkg::*;

	logic                      v_s1, v_s2;
	logic                      adv_s1, adv_s2;
	logic signed [TC_W-1:0]    tc_s1;
	logic signed [TCM_W-1:0]   tcm_s1;
	logic [RH2_W-1:0]          rh2_s1;
	logic [K2RH_W-1:0]         k2rh_s1;
	logic [KTS_W-1:0]          kts_s1;
	htc_prod_t                 prod_s2;

	// A stage advances when it is empty or its successor advances
	assign adv_s2       = !v_s2 || prod_ready;
	assign adv_s1       = !v_s1 || adv_s2;
	assign sample.ready = adv_s1;
	assign prod_valid   = v_s2;
	assign prod         = prod_s2;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= sample.valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	// Stage 1: offset temperature and products of raw humidity
	always_ff @(posedge clk) begin
		if (adv_s1 && sample.valid) begin
			tc_s1   <= TC_W'($signed({1'b0, sample.raw_temperature}))
				+ TC_W'(cfg.temp_offset);
			tcm_s1  <= TCM_W'($signed({1'b0, sample.raw_temperature}))
				+ TCM_W'(cfg.temp_offset) - TCM_W'(T_BASE);
			rh2_s1  <= RH2_W'(sample.raw_humidity) * RH2_W'(sample.raw_humidity);
			k2rh_s1 <= K2RH_W'(K2) * K2RH_W'(sample.raw_humidity);
			kts_s1  <= KTS_W'(KT1) + KTS_W'(KT2) * KTS_W'(sample.raw_humidity);
		end
	end

	// Stage 2: quadratic term, compensation product, saturation and alarm
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			prod_s2.k2rh  <= k2rh_s1;
			prod_s2.k3rh2 <= K3RH2_W'(K3) * K3RH2_W'(rh2_s1);
			prod_s2.tprod <= TPROD_W'(tcm_s1) * TPROD_W'($signed({1'b0, kts_s1}));
			prod_s2.alarm <= tc_s1 > TC_W'(cfg.alarm_threshold);
			if (tc_s1 > TC_W'(TEMP_MAX)) begin
				prod_s2.temperature <= TEMP_W'(TEMP_MAX);
			end else if (tc_s1 < TC_W'(TEMP_MIN)) begin
				prod_s2.temperature <= TEMP_W'(TEMP_MIN);
			end else begin
				prod_s2.temperature <= TEMP_W'(tc_s1);
			end
		end
	end

endmodule

/* rtl/htc_sum.sv */
// ----------------------------------------------------------------------------
// htc_sum: accumulation stages s3, s4 and output register
// s3 adds the linear and quadratic terms, offset and rounding half; s4 adds the
// temperature compensation; the output register rounds and clamps.
// ----------------------------------------------------------------------------
module htc_sum (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               prod_valid,
	output logic               prod_ready,
	input  htc_pkg::htc_prod_t prod,
	input  htc_pkg::htc_cfg_t  cfg,
	htc_out_if.source          result
);
	import htc_pkg::*;

	logic                     v_s3, v_s4, out_valid_q;
	logic                     adv_s3, adv_s4, adv_out;
	logic signed [ACC_W-1:0]  part_s3, acc_s4;
	logic signed [TPROD_W-1:0] tprod_s3;
	logic signed [TEMP_W-1:0] temp_s3, temp_s4, temp_q;
	logic                     alarm_s3, alarm_s4, alarm_q;
	logic [HUM_W-1:0]         hum_q;
	logic [HQ_W-1:0]          hq;
	logic [HUM_W-1:0]         hum_clamped;

	// Stall chain back from the output register
	assign adv_out    = !out_valid_q || result.ready;
	assign adv_s4     = !v_s4 || adv_out;
	assign adv_s3     = !v_s3 || adv_s4;
	assign prod_ready = adv_s3;

	assign result.valid             = out_valid_q;
	assign result.temperature_centi = temp_q;
	assign result.humidity_centi    = hum_q;
	assign result.alarm             = alarm_q;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s3)  v_s3        <= prod_valid;
			if (adv_s4)  v_s4        <= v_s3;
			if (adv_out) out_valid_q <= v_s4;
		end
	end

	// Stage 3: K2*rh - K3*rh^2 + offset*2^F + half
	always_ff @(posedge clk) begin
		if (adv_s3 && prod_valid) begin
			part_s3  <= ACC_W'($signed({1'b0, prod.k2rh}))
				- ACC_W'($signed({1'b0, prod.k3rh2}))
				+ ACC_W'($signed({cfg.humidity_offset, 1'b1, {(FRAC_BITS-1){1'b0}}}));
			tprod_s3 <= prod.tprod;
			temp_s3  <= prod.temperature;
			alarm_s3 <= prod.alarm;
		end
	end

	// Stage 4: add temperature compensation
	always_ff @(posedge clk) begin
		if (adv_s4 && v_s3) begin
			acc_s4   <= part_s3 + ACC_W'(tprod_s3);
			temp_s4  <= temp_s3;
			alarm_s4 <= alarm_s3;
		end
	end

	// Drop fraction and clamp to the humidity range
	assign hq = acc_s4[ACC_W-1:FRAC_BITS];

	always_comb begin
		if (acc_s4[ACC_W-1]) begin
			hum_clamped = HUM_W'(HUM_MIN);
		end else if (hq < HQ_W'(HUM_MIN)) begin
			hum_clamped = HUM_W'(HUM_MIN);
		end else if (hq > HQ_W'(HUM_MAX)) begin
			hum_clamped = HUM_W'(HUM_MAX);
		end else begin
			hum_clamped = hq[HUM_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (adv_out && v_s4) begin
			hum_q   <= hum_clamped;
			temp_q  <= temp_s4;
			alarm_q <= alarm_s4;
		end
	end

endmodule

/* rtl/htc_checker.sv */
// ----------------------------------------------------------------------------
// htc_checker: port-level checks of the converter
// Watches the sample and result channels for range, latency and stall
// behavior; attached to the top level by bind.
// ----------------------------------------------------------------------------
module htc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [htc_pkg::TEMP_W-1:0] out_temperature,
	input logic [htc_pkg::HUM_W-1:0]        out_humidity,
	input logic                             out_alarm
);
	import htc_pkg::*;

	// Humidity result stays inside the clamp limits
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_humidity >= HUM_W'(HUM_MIN)) && (out_humidity <= HUM_W'(HUM_MAX)))
		else $error("humidity result outside clamp limits");

	// With the result side ready, a sample shows up after passing s1, s2, s3, s4 and the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
		|=> out_valid)
		else $error("result missing five cycles after transaction");

	// Input back-pressure only when the result side is stalled
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("sample ready low without output stall");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(out_temperature)
		&& $stable(out_humidity) && $stable(out_alarm))
		else $error("stalled result changed");

endmodule

bind humidity_temperature_compensation_unit htc_checker u_htc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (sample.valid),
	.in_ready        (sample.ready),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.out_temperature (result.temperature_centi),
	.out_humidity    (result.humidity_centi),
	.out_alarm       (result.alarm)
);
